// ===== sv/vpsp_pkg.sv =====
`timescale 1ns / 1ps

package vpsp_pkg;

    localparam int DATA_W  = 8;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int TDATA_W = 48;

    // Field and result kinds share one encoding
    typedef enum logic {
        KIND_INDEX  = 1'b0,
        KIND_STRING = 1'b1
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        t_kind             field_kind;
    } t_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [VALUE_W-1:0] index_value;
        logic               char_valid;
        logic [DATA_W-1:0]  char_byte;
        logic               string_end;
    } t_result;

endpackage

// ===== sv/vpsp_core.sv =====
`timescale 1ns / 1ps

module vpsp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  vpsp_pkg::t_item  i_item,
    output logic             o_res_valid,
    output vpsp_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IDX,
        PH_LEN,
        PH_ANSI,
        PH_WLO,
        PH_WHI
    } t_phase;

    t_phase                             r_phase,     n_phase;
    logic [vpsp_pkg::VALUE_W-1:0]       r_acc,       n_acc;
    logic [vpsp_pkg::POS_W-1:0]         r_bit_pos,   n_bit_pos;
    logic                               r_neg,       n_neg;
    logic [vpsp_pkg::VALUE_W-1:0]       r_remaining, n_remaining;
    logic                               r_term,      n_term;
    logic [vpsp_pkg::DATA_W-1:0]        r_low,       n_low;

    logic [vpsp_pkg::DATA_W-1:0]        b;
    logic [vpsp_pkg::VALUE_W-1:0]       shifted;
    logic [vpsp_pkg::VALUE_W-1:0]       rem_dec;
    logic [vpsp_pkg::VALUE_W-1:0]       fin_acc;
    logic [vpsp_pkg::VALUE_W-1:0]       fin_val;
    logic                               fin_en;
    logic                               fin_len;
    logic                               fin_neg;
    logic                               emit;
    logic                               last;
    logic                               zero_pair;
    logic                               res_valid;
    vpsp_pkg::t_result                  res;

    assign b       = i_item.data_byte;
    assign shifted = {{(vpsp_pkg::VALUE_W-7){1'b0}}, b[6:0]} << r_bit_pos;
    assign rem_dec = r_remaining - {{(vpsp_pkg::VALUE_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_bit_pos   = r_bit_pos;
        n_neg       = r_neg;
        n_remaining = r_remaining;
        n_term      = r_term;
        n_low       = r_low;
        fin_en      = 1'b0;
        fin_len     = 1'b0;
        fin_neg     = 1'b0;
        fin_acc     = '0;
        emit        = 1'b0;
        last        = 1'b0;
        zero_pair   = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        case (r_phase)
            PH_IDX, PH_LEN: begin
                // Bits at position 32 and above are dropped
                if (r_bit_pos < 6'd32) begin
                    n_acc     = r_acc | shifted;
                    n_bit_pos = r_bit_pos + 6'd7;
                end
                if (!b[7]) begin
                    fin_en  = 1'b1;
                    fin_len = (r_phase == PH_LEN);
                    fin_acc = n_acc;
                    fin_neg = r_neg;
                end
            end
            PH_ANSI: begin
                emit        = !r_term && (b != '0);
                n_term      = r_term || (b == '0);
                n_remaining = rem_dec;
                last        = (rem_dec == '0);
                if (last) begin
                    n_phase = PH_IDLE;
                end
                if (emit || last) begin
                    res_valid        = 1'b1;
                    res.result_kind  = vpsp_pkg::KIND_STRING;
                    res.char_valid   = emit;
                    res.char_byte    = emit ? b : '0;
                    res.string_end   = last;
                end
            end
            PH_WLO: begin
                n_low   = b;
                n_phase = PH_WHI;
            end
            PH_WHI: begin
                zero_pair   = (r_low == '0) && (b == '0);
                emit        = !r_term && !zero_pair;
                n_term      = r_term || zero_pair;
                n_remaining = rem_dec;
                last        = (rem_dec == '0);
                n_phase     = last ? PH_IDLE : PH_WLO;
                if (emit || last) begin
                    res_valid        = 1'b1;
                    res.result_kind  = vpsp_pkg::KIND_STRING;
                    res.char_valid   = emit;
                    res.char_byte    = emit ? r_low : '0;
                    res.string_end   = last;
                end
            end
            default: begin
                // First byte of a field: sign, continue flag, 6 value bits
                n_neg     = b[7];
                n_acc     = {{(vpsp_pkg::VALUE_W-6){1'b0}}, b[5:0]};
                n_bit_pos = 6'd6;
                if (b[6]) begin
                    n_phase = (i_item.field_kind == vpsp_pkg::KIND_STRING) ? PH_LEN : PH_IDX;
                end else begin
                    fin_en  = 1'b1;
                    fin_len = (i_item.field_kind == vpsp_pkg::KIND_STRING);
                    fin_acc = n_acc;
                    fin_neg = b[7];
                end
            end
        endcase

        fin_val = fin_neg ? ('0 - fin_acc) : fin_acc;

        if (fin_en) begin
            if (!fin_len) begin
                n_phase          = PH_IDLE;
                res_valid        = 1'b1;
                res.result_kind  = vpsp_pkg::KIND_INDEX;
                res.index_value  = fin_val;
            end else begin
                n_term = 1'b0;
                n_low  = '0;
                if (fin_val == '0) begin
                    n_phase          = PH_IDLE;
                    n_remaining      = '0;
                    res_valid        = 1'b1;
                    res.result_kind  = vpsp_pkg::KIND_STRING;
                    res.string_end   = 1'b1;
                end else if (!fin_val[vpsp_pkg::VALUE_W-1]) begin
                    n_remaining = fin_val;
                    n_phase     = PH_ANSI;
                end else begin
                    // Negative length counts UTF-16LE pairs
                    n_remaining = '0 - fin_val;
                    n_phase     = PH_WLO;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_bit_pos   <= '0;
            r_neg       <= 1'b0;
            r_remaining <= '0;
            r_term      <= 1'b0;
            r_low       <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_bit_pos   <= n_bit_pos;
            r_neg       <= n_neg;
            r_remaining <= n_remaining;
            r_term      <= n_term;
            r_low       <= n_low;
        end
    end

    assign o_res_valid = i_fire && res_valid;
    assign o_res       = res;

endmodule

// ===== sv/vpsp_out_skid.sv =====
`timescale 1ns / 1ps

module vpsp_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vpsp_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output vpsp_pkg::t_result o_res
);

    logic              r_main_valid;
    logic              r_skid_valid;
    vpsp_pkg::t_result r_main;
    vpsp_pkg::t_result r_skid;
    logic              pop;

    assign pop = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                // Advance the held item; no push can arrive while skid is full
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main       <= i_res;
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main       <= i_res;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

endmodule

// ===== sv/varint_prefixed_string_parser.sv =====
`timescale 1ns / 1ps
// An accepted input item is held in the input register and parsed by vpsp_core;
// its result is registered in the output skid for the master side.
// Throughput: 1 item per cycle when not stalled; the parser state updates once per
// byte in vpsp_core. An input register feeds the parser and a two-entry output skid
// holds results, so input stalls only while both output entries are full.
// Reset (synchronous, active low) empties both stages and returns the parser to idle.
module varint_prefixed_string_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [vpsp_pkg::DATA_W-1:0]   i_s_tdata,  // [7:0] data_byte
    input  logic                          i_s_tuser,  // [0] field_kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [vpsp_pkg::TDATA_W-1:0]  o_m_tdata,  // [31:0] index_value, [32] char_valid,
                                                      // [40:33] char_byte, [47:41] zero
    output logic                          o_m_tuser,  // [0] result_kind
    output logic                          o_m_tlast   // string_end
);

    logic              r_in_valid;
    vpsp_pkg::t_item   r_in;
    logic              fire;
    logic              skid_full;
    logic              res_valid;
    vpsp_pkg::t_result res;
    vpsp_pkg::t_result out_res;

    assign fire       = r_in_valid && !skid_full;
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
            r_in.data_byte  <= i_s_tdata;
            r_in.field_kind <= vpsp_pkg::t_kind'(i_s_tuser);
        end
    end

    vpsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    vpsp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (skid_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {{(vpsp_pkg::TDATA_W-vpsp_pkg::VALUE_W-vpsp_pkg::DATA_W-1){1'b0}},
                        out_res.char_byte, out_res.char_valid, out_res.index_value};
    assign o_m_tuser = out_res.result_kind;
    assign o_m_tlast = out_res.string_end;

endmodule

// ===== tb/varint_parse_checker.sv =====
`timescale 1ns / 1ps

module varint_parse_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [vpsp_pkg::DATA_W-1:0]   i_s_tdata,   // [7:0] data_byte
    input  logic                          i_s_tuser,   // [0] field_kind
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [vpsp_pkg::TDATA_W-1:0]  i_m_tdata,   // [31:0] index_value, [32] char_valid,
                                                       // [40:33] char_byte, [47:41] zero
    input  logic                          i_m_tuser,   // [0] result_kind
    input  logic                          i_m_tlast,   // string_end
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int EXP_DEPTH = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_LENGTH,
        ST_ANSI,
        ST_WIDE_LO,
        ST_WIDE_HI
    } t_phase;

    t_phase                       phase;
    logic [vpsp_pkg::VALUE_W-1:0] acc;
    logic [vpsp_pkg::POS_W-1:0]   bit_pos;
    logic                         neg;
    logic [vpsp_pkg::VALUE_W-1:0] units_left;
    logic                         term_seen;
    logic [vpsp_pkg::DATA_W-1:0]  wide_low;

    vpsp_pkg::t_result exp_q [EXP_DEPTH];
    int                exp_head       = 0;
    int                exp_tail       = 0;
    int                mismatch_count = 0;
    int                waiting        = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = waiting;

    // Close a compact index: an index result, an empty-string result or the start of a string payload
    function automatic logic close_index(input logic is_len, output vpsp_pkg::t_result ev);
        logic [vpsp_pkg::VALUE_W-1:0] v;
        v  = neg ? (32'd0 - acc) : acc;
        ev = '0;
        if (!is_len) begin
            phase          = ST_IDLE;
            ev.result_kind = vpsp_pkg::KIND_INDEX;
            ev.index_value = v;
            return 1'b1;
        end
        term_seen = 1'b0;
        wide_low  = '0;
        if (v == 32'd0) begin
            phase          = ST_IDLE;
            units_left     = '0;
            ev.result_kind = vpsp_pkg::KIND_STRING;
            ev.string_end  = 1'b1;
            return 1'b1;
        end
        if (!v[vpsp_pkg::VALUE_W-1]) begin
            units_left = v;
            phase      = ST_ANSI;
        end else begin
            // minus 2^31 negates to itself and still counts as 2^31 pairs
            units_left = 32'd0 - v;
            phase      = ST_WIDE_LO;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        vpsp_pkg::t_result           want;
        vpsp_pkg::t_result           got;
        logic                        has_result;
        logic [vpsp_pkg::DATA_W-1:0] b;
        if (!i_rst_n) begin
            phase      = ST_IDLE;
            acc        = '0;
            bit_pos    = '0;
            neg        = 1'b0;
            units_left = '0;
            term_seen  = 1'b0;
            wide_low   = '0;
            exp_head   = 0;
            exp_tail   = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                b          = i_s_tdata;
                want       = '0;
                has_result = 1'b0;
                case (phase)
                    ST_INDEX, ST_LENGTH: begin
                        // drop value bits once the position passes the word
                        if (bit_pos < 32) begin
                            acc     = acc | (32'(b[6:0]) << bit_pos);
                            bit_pos = bit_pos + 6'd7;
                        end
                        if (!b[7]) has_result = close_index(phase == ST_LENGTH, want);
                    end
                    ST_ANSI: begin
                        has_result = !term_seen && (b != 8'h00);
                        if (b == 8'h00) term_seen = 1'b1;
                        units_left       = units_left - 32'd1;
                        want.result_kind = vpsp_pkg::KIND_STRING;
                        want.char_valid  = has_result;
                        want.char_byte   = has_result ? b : 8'h00;
                        want.string_end  = (units_left == 32'd0);
                        if (want.string_end) phase = ST_IDLE;
                        has_result = has_result || want.string_end;
                    end
                    ST_WIDE_LO: begin
                        wide_low = b;
                        phase    = ST_WIDE_HI;
                    end
                    ST_WIDE_HI: begin
                        has_result = !term_seen && !(wide_low == 8'h00 && b == 8'h00);
                        if (wide_low == 8'h00 && b == 8'h00) term_seen = 1'b1;
                        units_left       = units_left - 32'd1;
                        want.result_kind = vpsp_pkg::KIND_STRING;
                        want.char_valid  = has_result;
                        want.char_byte   = has_result ? wide_low : 8'h00;
                        want.string_end  = (units_left == 32'd0);
                        phase            = want.string_end ? ST_IDLE : ST_WIDE_LO;
                        has_result       = has_result || want.string_end;
                    end
                    default: begin
                        neg     = b[7];
                        acc     = {26'd0, b[5:0]};
                        bit_pos = 6'd6;
                        if (b[6]) begin
                            phase = (i_s_tuser == vpsp_pkg::KIND_STRING) ? ST_LENGTH
                                                                         : ST_INDEX;
                        end else begin
                            has_result = close_index(i_s_tuser == vpsp_pkg::KIND_STRING,
                                                     want);
                        end
                    end
                endcase
                if (has_result) begin
                    if (exp_tail - exp_head >= EXP_DEPTH) begin
                        $error("expected results overflow: %0d waiting", exp_tail - exp_head);
                        mismatch_count++;
                    end else begin
                        exp_q[exp_tail % EXP_DEPTH] = want;
                        exp_tail++;
                    end
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                got.result_kind = vpsp_pkg::t_kind'(i_m_tuser);
                got.index_value = i_m_tdata[31:0];
                got.char_valid  = i_m_tdata[32];
                got.char_byte   = i_m_tdata[40:33];
                got.string_end  = i_m_tlast;
                if (exp_tail == exp_head) begin
                    $error("unexpected result: kind %0d value %h char %h end %0d",
                           got.result_kind, got.index_value, got.char_byte,
                           got.string_end);
                    mismatch_count++;
                end else begin
                    want = exp_q[exp_head % EXP_DEPTH];
                    exp_head++;
                    if (got.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, got.result_kind);
                        mismatch_count++;
                    end
                    if (got.index_value !== want.index_value) begin
                        $error("index_value: expected %0d, got %0d",
                               $signed(want.index_value), $signed(got.index_value));
                        mismatch_count++;
                    end
                    if (got.char_valid !== want.char_valid) begin
                        $error("char_valid: expected %0d, got %0d",
                               want.char_valid, got.char_valid);
                        mismatch_count++;
                    end
                    if (got.char_byte !== want.char_byte) begin
                        $error("char_byte: expected %h, got %h",
                               want.char_byte, got.char_byte);
                        mismatch_count++;
                    end
                    if (got.string_end !== want.string_end) begin
                        $error("string_end: expected %0d, got %0d",
                               want.string_end, got.string_end);
                        mismatch_count++;
                    end
                end
            end
        end
        waiting = exp_tail - exp_head;
    end

endmodule

// ===== tb/tb_varint_prefixed_string_parser.sv =====
`timescale 1ns / 1ps

module tb_varint_prefixed_string_parser;

    localparam int RANDOM_BYTES   = 360;
    localparam int CALM_AFTER     = 300;
    localparam int HOLD_START     = 250;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [vpsp_pkg::DATA_W-1:0]  s_tdata  = '0;
    logic                         s_tuser  = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [vpsp_pkg::TDATA_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    int fail_count;
    int pending;
    int bytes_sent   = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    varint_prefixed_string_parser u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    varint_parse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_varint_prefixed_string_parser: FAIL");
            $finish;
        end
    end

    // Receiver: short random stalls, one long hold-off early on, none at the end
    initial begin
        int span;
        int elapsed;
        bit held;
        elapsed = 0;
        held    = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && elapsed >= HOLD_START) begin
                held     = 1'b1;
                m_tready <= 1'b0;
                span     = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                span     = $urandom_range(1, 13);
            end else begin
                m_tready <= 1'b1;
                span     = $urandom_range(1, 24);
            end
            repeat (span) @(posedge clk);
            elapsed += span;
        end
    end

    task automatic offer_byte(input logic [vpsp_pkg::DATA_W-1:0] b, input vpsp_pkg::t_kind k);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= k;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Encode a compact index; bytes after the first carry a random kind, which is ignored
    task automatic offer_varint(input vpsp_pkg::t_kind k, input logic neg,
                                input logic [63:0] mag, input int nbytes);
        logic [63:0] rest;
        int          i;
        rest = mag >> 6;
        offer_byte({neg, nbytes > 1, mag[5:0]}, k);
        for (i = 1; i < nbytes; i++) begin
            offer_byte({i < nbytes - 1, rest[6:0]}, vpsp_pkg::t_kind'($urandom_range(0, 1)));
            rest = rest >> 7;
        end
    endtask

    task automatic offer_wide_pairs(input int count);
        logic [vpsp_pkg::DATA_W-1:0] lo;
        logic [vpsp_pkg::DATA_W-1:0] hi;
        int                          i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                lo = 8'h00;
                hi = 8'h00;
            end else begin
                lo = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                hi = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            end
            offer_byte(lo, vpsp_pkg::t_kind'($urandom_range(0, 1)));
            offer_byte(hi, vpsp_pkg::t_kind'($urandom_range(0, 1)));
        end
    endtask

    function automatic int varint_bytes(input logic [63:0] mag);
        int n;
        n = 1;
        while ((mag >> (6 + 7 * (n - 1))) != 0) n++;
        return n;
    endfunction

    initial begin
        logic [63:0] mag;
        int          nbytes;
        int          units;
        bit          wide;
        int          i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // index extremes: zero, largest positive, most negative, overlong all-ones
        offer_varint(vpsp_pkg::KIND_INDEX, 1'b0, 64'd0, 1);
        offer_varint(vpsp_pkg::KIND_INDEX, 1'b0, 64'h7FFF_FFFF, 5);
        offer_varint(vpsp_pkg::KIND_INDEX, 1'b1, 64'h8000_0000, 5);
        offer_varint(vpsp_pkg::KIND_INDEX, 1'b1, '1, 7);
        // empty strings, plain and with a negative zero length
        offer_varint(vpsp_pkg::KIND_STRING, 1'b0, 64'd0, 1);
        offer_varint(vpsp_pkg::KIND_STRING, 1'b1, 64'd0, 1);
        // ANSI string with a NUL in the middle
        offer_varint(vpsp_pkg::KIND_STRING, 1'b0, 64'd3, 1);
        offer_byte(8'h41, vpsp_pkg::KIND_STRING);
        offer_byte(8'h00, vpsp_pkg::KIND_INDEX);
        offer_byte(8'h42, vpsp_pkg::KIND_STRING);
        // wide string ending in a zero pair
        offer_varint(vpsp_pkg::KIND_STRING, 1'b1, 64'd2, 1);
        offer_byte(8'h41, vpsp_pkg::KIND_INDEX);
        offer_byte(8'h00, vpsp_pkg::KIND_STRING);
        offer_byte(8'h00, vpsp_pkg::KIND_INDEX);
        offer_byte(8'h00, vpsp_pkg::KIND_STRING);

        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= CALM_AFTER) calm = 1'b1;
            if ($urandom_range(0, 9) < 4) begin
                nbytes = $urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom_range(3, 7);
                mag    = {$urandom, $urandom};
                offer_varint(vpsp_pkg::KIND_INDEX, 1'($urandom_range(0, 1)), mag, nbytes);
            end else begin
                wide = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 7) == 0) begin
                    units = 0;
                end else begin
                    units = wide ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
                mag    = 64'(units);
                nbytes = varint_bytes(mag);
                if ($urandom_range(0, 9) == 0) begin
                    // junk above the word must be dropped
                    mag    = mag | (64'($urandom_range(1, 16383)) << 34);
                    nbytes = 7;
                end else if ($urandom_range(0, 3) == 0) begin
                    nbytes = nbytes + $urandom_range(1, 2);
                end
                offer_varint(vpsp_pkg::KIND_STRING, wide, mag, nbytes);
                if (wide) begin
                    offer_wide_pairs(units);
                end else begin
                    for (i = 0; i < units; i++) begin
                        offer_byte(($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom),
                                   vpsp_pkg::t_kind'($urandom_range(0, 1)));
                    end
                end
            end
        end

        // length of minus 2^31 never finishes, so it goes last
        calm = 1'b1;
        offer_varint(vpsp_pkg::KIND_STRING, 1'b1, 64'h8000_0000, 5);
        offer_wide_pairs(12);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_varint_prefixed_string_parser: PASS");
        end else begin
            $display("tb_varint_prefixed_string_parser: FAIL");
        end
        $finish;
    end

endmodule
